// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the collision scan core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication property holds on every rising clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is never true on a rising clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/cpcs_pkg.sv =====
// Package with the types and constants of the circle pair collision scan core.
package cpcs_pkg;

	localparam int DEF_MAX_CIRCLES = 8;
	localparam int COORD_W         = 16;
	localparam int INDEX_OUT_W     = 3;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0]        radius;
		logic                      final_circle;
	} cpcs_in_t;

	typedef struct packed {
		logic [INDEX_OUT_W-1:0] first_index;
		logic [INDEX_OUT_W-1:0] second_index;
		logic                   pair_valid;
		logic                   dropped;
		logic                   run_end;
	} cpcs_out_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_CLOSE
	} cpcs_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic issue;
	} cpcs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pipe_busy;
		logic hit;
	} cpcs_status_t;

endpackage

// ===== rtl/core/cpcs_dp.sv =====
// Datapath: circle stores and the pipelined pair distance test.
module cpcs_dp #(
	parameter int MAX_CIRCLES = cpcs_pkg::DEF_MAX_CIRCLES,
	parameter int IDX_W       = $clog2(MAX_CIRCLES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cpcs_pkg::cpcs_cmd_t    cmd,
	input  logic [IDX_W-1:0]       wr_addr,
	input  logic [IDX_W-1:0]       rd_i,
	input  logic [IDX_W-1:0]       rd_j,
	input  cpcs_pkg::cpcs_in_t     circle,
	output cpcs_pkg::cpcs_status_t status,
	output logic [IDX_W-1:0]       hit_i,
	output logic [IDX_W-1:0]       hit_j
);
	import cpcs_pkg::*;

	logic signed [COORD_W-1:0] x_mem [MAX_CIRCLES];
	logic signed [COORD_W-1:0] y_mem [MAX_CIRCLES];
	logic [COORD_W-1:0]        r_mem [MAX_CIRCLES];

	logic signed [COORD_W-1:0] xi_s1, xj_s1, yi_s1, yj_s1;
	logic [COORD_W-1:0]        ri_s1, rj_s1;
	logic [IDX_W-1:0]          i_s1, j_s1, i_s2, j_s2, i_s3, j_s3, i_s4, j_s4;
	logic                      v_s1, v_s2, v_s3, hit_s4;

	logic [COORD_W-1:0]        adx_s2, ady_s2;
	logic [COORD_W:0]          rsum_s2;
	logic [2*COORD_W-1:0]      sqx_s3, sqy_s3;
	logic [2*COORD_W+1:0]      rsq_s3;

	logic signed [COORD_W:0]   dx, dy;
	logic signed [COORD_W:0]   ndx, ndy;
	logic [2*COORD_W:0]        dist2;
	logic                      collide;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_mem[wr_addr] <= circle.pos_x;
			y_mem[wr_addr] <= circle.pos_y;
			r_mem[wr_addr] <= circle.radius;
		end
	end

	// Stage 1: registered reads of both circles of the pair
	always_ff @(posedge clk) begin
		xi_s1 <= x_mem[rd_i];
		xj_s1 <= x_mem[rd_j];
		yi_s1 <= y_mem[rd_i];
		yj_s1 <= y_mem[rd_j];
		ri_s1 <= r_mem[rd_i];
		rj_s1 <= r_mem[rd_j];
		i_s1  <= rd_i;
		j_s1  <= rd_j;
	end

	// Stage 2: differences as magnitudes, radius sum
	always_comb begin
		dx  = (COORD_W+1)'(xi_s1) - (COORD_W+1)'(xj_s1);
		dy  = (COORD_W+1)'(yi_s1) - (COORD_W+1)'(yj_s1);
		ndx = -dx;
		ndy = -dy;
	end

	always_ff @(posedge clk) begin
		adx_s2  <= dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
		ady_s2  <= dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
		rsum_s2 <= (COORD_W+1)'(ri_s1) + (COORD_W+1)'(rj_s1);
		i_s2    <= i_s1;
		j_s2    <= j_s1;
	end

	// Stage 3: squares
	always_ff @(posedge clk) begin
		sqx_s3 <= adx_s2 * adx_s2;
		sqy_s3 <= ady_s2 * ady_s2;
		rsq_s3 <= rsum_s2 * rsum_s2;
		i_s3   <= i_s2;
		j_s3   <= j_s2;
	end

	// Stage 4: distance sum against squared radius sum, touching counts
	always_comb begin
		dist2   = (2*COORD_W+1)'(sqx_s3) + (2*COORD_W+1)'(sqy_s3);
		collide = (2*COORD_W+2)'(dist2) <= rsq_s3;
	end

	always_ff @(posedge clk) begin
		i_s4 <= i_s3;
		j_s4 <= j_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			hit_s4 <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			hit_s4 <= v_s3 & collide;
		end
	end

	assign status.pipe_busy = v_s1 | v_s2 | v_s3;
	assign status.hit       = hit_s4;
	assign hit_i            = i_s4;
	assign hit_j            = j_s4;

endmodule

// ===== rtl/core/cpcs_ctrl.sv =====
// Controller: load counting, pair walk and closing sequence.
module cpcs_ctrl #(
	parameter int MAX_CIRCLES = cpcs_pkg::DEF_MAX_CIRCLES,
	parameter int IDX_W       = $clog2(MAX_CIRCLES),
	parameter int CNT_W       = $clog2(MAX_CIRCLES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   final_circle,
	input  cpcs_pkg::cpcs_status_t status,
	output cpcs_pkg::cpcs_cmd_t    cmd,
	output logic [IDX_W-1:0]       wr_addr,
	output logic [IDX_W-1:0]       rd_i,
	output logic [IDX_W-1:0]       rd_j,
	output logic                   busy,
	output logic                   closing,
	output logic                   dropped
);
	import cpcs_pkg::*;

	cpcs_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ovf_q;
	logic [IDX_W-1:0] i_q, j_q;
	logic             accept, has_room, last_col, last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		accept   = start & (state_q == ST_LOAD);
		has_room = cnt_q < CNT_W'(MAX_CIRCLES);
		cnt_d    = has_room ? cnt_q + CNT_W'(1) : cnt_q;
		last_col = CNT_W'(j_q) == cnt_q - CNT_W'(1);
		last_row = CNT_W'(i_q) == cnt_q - CNT_W'(2);
		state_d  = state_q;
		cmd      = '0;
		busy     = 1'b1;
		closing  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				busy     = 1'b0;
				cmd.load = accept & has_room;
				if (accept && final_circle) begin
					state_d = (cnt_d < CNT_W'(2)) ? ST_CLOSE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (last_col && last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				closing = 1'b1;
				state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			i_q   <= '0;
			j_q   <= '0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
				if (!has_room) begin
					ovf_q <= 1'b1;
				end
				i_q <= '0;
				j_q <= IDX_W'(1);
			end else if (state_q == ST_SCAN) begin
				if (last_col) begin
					i_q <= i_q + IDX_W'(1);
					j_q <= i_q + IDX_W'(2);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end else if (state_q == ST_CLOSE) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	assign wr_addr = cnt_q[IDX_W-1:0];
	assign rd_i    = i_q;
	assign rd_j    = j_q;
	assign dropped = ovf_q;

endmodule

// ===== rtl/core/circle_pair_collision_scan_core.sv =====
// Top level of the circle pair collision scan core.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-----------------------
//  circle   | in        | start high while busy is low  | cpcs_in_t (x, y, r, final)
//  result   | out       | strobe high for one cycle     | cpcs_out_t (pair, flags)
//
// Busy stays low throughout the load phase, so circles can be loaded back to back.
// The circle that carries final_circle starts the scan: one pair of n loaded
// circles enters the distance pipeline each cycle until all n*(n-1)/2 pairs
// have entered, then the four-stage pipeline flushes and the closing
// transaction follows (fewer than two circles go straight to closing).
// Busy is high for the whole scan phase.
// Reset clears the controller and the pipeline valid bits; store contents
// are undefined until loaded. The receiver cannot stall: each result
// transaction is presented for exactly one cycle.
module circle_pair_collision_scan_core #(
	parameter int MAX_CIRCLES = cpcs_pkg::DEF_MAX_CIRCLES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cpcs_pkg::cpcs_in_t  circle,
	output logic                strobe,
	output cpcs_pkg::cpcs_out_t result
);
	import cpcs_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(MAX_CIRCLES);
	localparam int CNT_W = $clog2(MAX_CIRCLES + 1);

	cpcs_cmd_t        cmd;
	cpcs_status_t     dp_status;
	logic [IDX_W-1:0] wr_addr, rd_i, rd_j, hit_i, hit_j;
	logic             closing, dropped;

	cpcs_ctrl #(
		.MAX_CIRCLES (MAX_CIRCLES),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.final_circle (circle.final_circle),
		.status       (dp_status),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_i         (rd_i),
		.rd_j         (rd_j),
		.busy         (busy),
		.closing      (closing),
		.dropped      (dropped)
	);

	cpcs_dp #(
		.MAX_CIRCLES (MAX_CIRCLES),
		.IDX_W       (IDX_W)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_i    (rd_i),
		.rd_j    (rd_j),
		.circle  (circle),
		.status  (dp_status),
		.hit_i   (hit_i),
		.hit_j   (hit_j)
	);

	// Colliding pairs come out of the pipeline; the closing transaction comes
	// from the controller once the pipeline is empty. Indices wrap to 3 bits.
	always_comb begin
		strobe              = dp_status.hit | closing;
		result.pair_valid   = dp_status.hit;
		result.run_end      = closing;
		result.dropped      = dropped;
		result.first_index  = closing ? '0 : INDEX_OUT_W'(hit_i);
		result.second_index = closing ? '0 : INDEX_OUT_W'(hit_j);
	end

	// A pair hit and the closing transaction never share a cycle.
	`ASSERT_NEVER(a_hit_close_apart, clk, arst_n, dp_status.hit && closing, "pair hit during close")

	// Reported pairs keep the lower index first.
	`ASSERT_PROP(a_pair_order, clk, arst_n, dp_status.hit |-> (hit_i < hit_j), "pair out of order")

	// The load phase sees an empty pipeline.
	`ASSERT_PROP(a_idle_empty, clk, arst_n, !busy |-> (!dp_status.pipe_busy && !dp_status.hit), "pipeline active while idle")

	// After the closing transaction the block returns to loading.
	`ASSERT_PROP(a_close_idle, clk, arst_n, closing |=> !busy, "busy after closing transaction")

endmodule

// ===== bench/circle_pair_collision_scan_core_test.sv =====
// Self-checking testbench for the circle pair collision scan core.
`timescale 1ns / 100ps

module circle_pair_collision_scan_core_test;
	import cpcs_pkg::*;

	localparam int CAPACITY       = DEF_MAX_CIRCLES;
	localparam int RANDOM_ITEMS   = 318;
	// Stop gaps for the last circles so the tail of the run is back to back.
	localparam int CALM_TAIL      = 50;
	// Long enough for one full scan of eight circles plus the pipeline flush.
	localparam int END_SETTLE     = 40;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int IN_W           = $bits(cpcs_in_t);

	// How the random circles of one set are spread over the plane.
	typedef enum int {
		SPREAD_CLUSTER,
		SPREAD_WIDE,
		SPREAD_GRID,
		SPREAD_EXTREME
	} spread_t;

	// Scoreboard: mirror the circle store, predict the colliding pairs of each set
	// and match them in order against the result transactions.
	class collision_ledger;
		cpcs_in_t  slots [CAPACITY];
		int        loaded;
		bit        overflowed;
		cpcs_out_t awaited [$];
		int        mismatches;

		function new();
			loaded     = 0;
			overflowed = 1'b0;
			mismatches = 0;
		endfunction

		// Exact test; touching circles count as colliding.
		function bit circles_meet(int a, int b);
			longint dx, dy, reach;
			dx    = longint'($signed(slots[a].pos_x)) - longint'($signed(slots[b].pos_x));
			dy    = longint'($signed(slots[a].pos_y)) - longint'($signed(slots[b].pos_y));
			reach = longint'(slots[a].radius) + longint'(slots[b].radius);
			return dx * dx + dy * dy <= reach * reach;
		endfunction

		function void scan_pairs();
			cpcs_out_t hit;
			for (int a = 0; a + 1 < loaded; a++) begin
				for (int b = a + 1; b < loaded; b++) begin
					if (circles_meet(a, b)) begin
						hit.first_index  = INDEX_OUT_W'(a);
						hit.second_index = INDEX_OUT_W'(b);
						hit.pair_valid   = 1'b1;
						hit.dropped      = overflowed;
						hit.run_end      = 1'b0;
						awaited.push_back(hit);
					end
				end
			end
			hit              = '0;
			hit.dropped      = overflowed;
			hit.run_end      = 1'b1;
			awaited.push_back(hit);
			loaded     = 0;
			overflowed = 1'b0;
		endfunction

		// Store the circle, or drop it when full; the final circle scans either way.
		function void note_circle(cpcs_in_t c);
			if (loaded < CAPACITY) begin
				slots[loaded] = c;
				loaded++;
			end else begin
				overflowed = 1'b1;
			end
			if (c.final_circle)
				scan_pairs();
		endfunction

		task report_mismatch(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_result(cpcs_out_t got);
			cpcs_out_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result %p with nothing expected", got));
				return;
			end
			want = awaited.pop_front();
			if (got.first_index !== want.first_index)
				report_mismatch($sformatf("first_index %0d, expected %0d",
					got.first_index, want.first_index));
			if (got.second_index !== want.second_index)
				report_mismatch($sformatf("second_index %0d, expected %0d",
					got.second_index, want.second_index));
			if (got.pair_valid !== want.pair_valid)
				report_mismatch($sformatf("pair_valid %b, expected %b",
					got.pair_valid, want.pair_valid));
			if (got.dropped !== want.dropped)
				report_mismatch($sformatf("dropped %b, expected %b",
					got.dropped, want.dropped));
			if (got.run_end !== want.run_end)
				report_mismatch($sformatf("run_end %b, expected %b",
					got.run_end, want.run_end));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	cpcs_in_t  circle;
	logic      strobe;
	cpcs_out_t result;

	collision_ledger ledger;
	int              circles_sent;
	int              idle_cycles;

	circle_pair_collision_scan_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.circle (circle),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	// Monitor: sample both channels at the rising edge, before the block's own
	// updates land. Check results first; a final circle never shares its edge
	// with a result of its own set.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				ledger.check_result(result);
			if (start && !busy)
				ledger.note_circle(circle);
			// Count cycles in which no transaction moves on either side.
			if (strobe || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: watchdog expired", $time);
				$display("circle_pair_collision_scan_core_test NOT OK");
				$finish;
			end
		end
	end

	function automatic cpcs_in_t make_circle(int x, int y, int r, bit last);
		cpcs_in_t c;
		c.pos_x        = 16'(x);
		c.pos_y        = 16'(y);
		c.radius       = 16'(r);
		c.final_circle = last;
		return c;
	endfunction

	function automatic logic [15:0] pick_coord(spread_t spread);
		case (spread)
			SPREAD_CLUSTER: return 16'($urandom_range(600) - 300);
			SPREAD_GRID:    return 16'($urandom_range(12) - 6);
			SPREAD_EXTREME: begin
				case ($urandom_range(3))
					0:       return 16'h8000;
					1:       return 16'h7fff;
					2:       return 16'hffff;
					default: return 16'($urandom);
				endcase
			end
			default:        return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_radius(spread_t spread);
		case (spread)
			SPREAD_CLUSTER: return 16'($urandom_range(200));
			SPREAD_GRID:    return 16'($urandom_range(5));
			SPREAD_EXTREME: begin
				case ($urandom_range(3))
					0:       return 16'h0000;
					1:       return 16'hffff;
					2:       return 16'h8000;
					default: return 16'($urandom);
				endcase
			end
			default:        return 16'($urandom);
		endcase
	endfunction

	// Present one circle and hold it until the block takes it. Leave start high
	// afterwards: the caller either presents the next circle or goes idle.
	task send_circle(cpcs_in_t c);
		circle <= c;
		start  <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		circles_sent++;
	endtask

	// Drop start for a burst and wiggle the circle bus as noise.
	task idle_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) begin
			circle <= cpcs_in_t'(IN_W'({$urandom, $urandom}));
			@(posedge clk);
		end
	endtask

	// Hold off until every predicted result has come back. Pass one edge first
	// so the monitor has noted the last accepted circle.
	task drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.awaited.size() != 0)
			@(posedge clk);
	endtask

	task send_set(int size, spread_t spread, bit lively);
		cpcs_in_t c;
		for (int k = 0; k < size; k++) begin
			c.pos_x        = pick_coord(spread);
			c.pos_y        = pick_coord(spread);
			c.radius       = pick_radius(spread);
			c.final_circle = (k == size - 1);
			send_circle(c);
			if (lively && $urandom_range(3) == 0)
				idle_sender($urandom_range(1, 15));
		end
	endtask

	initial begin
		int      size;
		int      set_no;
		int      roll;
		bit      calm;
		spread_t spread;

		ledger       = new();
		circles_sent = 0;
		idle_cycles  = 0;
		start        = 1'b0;
		circle       = '0;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A lone circle: no pairs, only the closing transaction.
		send_circle(make_circle(-32768, 32767, 65535, 1'b1));
		// Touching at distance 5 with radii 3 and 2: collides.
		send_circle(make_circle(0, 0, 3, 1'b0));
		send_circle(make_circle(3, 4, 2, 1'b1));
		// One unit short of touching: no pair.
		send_circle(make_circle(0, 0, 3, 1'b0));
		send_circle(make_circle(3, 4, 1, 1'b1));
		// Corners of the plane with largest and zero radii.
		send_circle(make_circle(-32768, -32768, 65535, 1'b0));
		send_circle(make_circle(32767, 32767, 65535, 1'b0));
		send_circle(make_circle(-32768, 32767, 0, 1'b0));
		send_circle(make_circle(32767, -32768, 0, 1'b1));
		drain_results();
		// Nine coincident points: fill the store, then drop the final circle
		// itself; all 28 pairs touch at zero distance and carry dropped.
		for (int k = 0; k < CAPACITY + 1; k++)
			send_circle(make_circle(-1, -1, 0, k == CAPACITY));
		drain_results();

		// Random sets, mostly within capacity, some overflowing, a few lone circles.
		set_no = 0;
		while (circles_sent < RANDOM_ITEMS) begin
			calm = circles_sent >= RANDOM_ITEMS - CALM_TAIL;
			roll = $urandom_range(19);
			if (roll < 2)
				size = 1;
			else if (roll < 5)
				size = $urandom_range(CAPACITY + 1, CAPACITY + 3);
			else
				size = $urandom_range(2, CAPACITY);
			spread = spread_t'($urandom_range(SPREAD_EXTREME));
			send_set(size, spread, !calm);
			// Now and then wait out the whole scan with the sender quiet.
			if (!calm && set_no % 8 == 3)
				drain_results();
			else if (!calm && $urandom_range(2) == 0)
				idle_sender($urandom_range(1, 15));
			set_no++;
		end

		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		if (ledger.awaited.size() != 0)
			ledger.report_mismatch($sformatf("%0d results never arrived",
				ledger.awaited.size()));
		if (ledger.mismatches == 0)
			$display("circle_pair_collision_scan_core_test OK");
		else
			$display("circle_pair_collision_scan_core_test NOT OK");
		$finish;
	end

endmodule
